FILE: src/nsdt_pkg.sv
// ----------------------------------------------------------------------------
// nsdt_pkg
// Types, widths and status codes for the nested scope duration tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsdt_pkg;

    localparam int MAX_RECORDS = 4096;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int ID_W    = 12;
    localparam int DEPTH_W = 13;
    localparam int TIME_W  = 64;
    localparam int NAME_W  = 16;
    localparam int STAT_W  = 3;

    localparam logic       FUNC_PUSH = 1'b0;
    localparam logic       FUNC_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK              = 3'd0;
    localparam logic [STAT_W-1:0] ST_PUSH_MISMATCH   = 3'd1;
    localparam logic [STAT_W-1:0] ST_POP_NOT_CURRENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL            = 3'd3;
    localparam logic [STAT_W-1:0] ST_POP_ROOT        = 3'd4;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   scope_id;
        logic [TIME_W-1:0] time_point;
        logic [NAME_W-1:0] name_tag;
    } nsdt_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    record_id;
        logic [ID_W-1:0]    parent_id;
        logic [DEPTH_W-1:0] nest_depth;
        logic [TIME_W-1:0]  begin_time;
        logic [TIME_W-1:0]  duration;
        logic [NAME_W-1:0]  scope_name;
    } nsdt_out_t;

    // one stored scope record
    typedef struct packed {
        logic [ID_W-1:0]    parent;
        logic [TIME_W-1:0]  begin_t;
        logic [DEPTH_W-1:0] depth;
        logic [NAME_W-1:0]  name;
    } nsdt_rec_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        nsdt_rec_t         wr_data;
    } nsdt_mem_req_t;

endpackage

`default_nettype wire

FILE: src/nested_scope_duration_tracker.sv
// ----------------------------------------------------------------------------
// nested_scope_duration_tracker
// Push/pop tracker for nested timed scopes with a record store per scope.
//
//   channel | ports                      | beat
//   input   | s_valid s_ready s_data     | nsdt_in_t  (func, id, time, tag)
//   result  | m_valid m_ready m_data     | nsdt_out_t (status, record fields)
//
// For each event the record is read from the store at accept; in the next
// cycle the status is decided, a push writes its record back and a good pop
// takes the current scope from the parent id of that record.
// Reset (aresetn low, synchronous) returns to the root scope, level 1, count 1;
// the record store is not cleared.
// A result waits in the output register; a new beat is taken as it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_scope_duration_tracker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire nsdt_pkg::nsdt_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output nsdt_pkg::nsdt_out_t      m_data
);
    import nsdt_pkg::*;

    nsdt_mem_req_t mem_req;
    nsdt_rec_t     rd_data;
    nsdt_out_t     res_data;
    logic          res_load;
    logic          out_free;

    logic          m_valid_reg, m_valid_next;
    nsdt_out_t     m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    nsdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .res_load (res_load),
        .res_data (res_data),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    nsdt_rec_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a result beat is never loaded over one still waiting
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !m_valid_reg || m_ready)
        else $error("result beat overwritten");

    a_one_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("accepted beat produced no result");

    a_no_accept_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !s_ready)
        else $error("beat accepted during execute");

endmodule

`default_nettype wire

FILE: src/nsdt_rec_mem.sv
// ----------------------------------------------------------------------------
// nsdt_rec_mem
// Scope record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsdt_rec_mem (
    input  wire logic                  aclk,
    input  wire nsdt_pkg::nsdt_mem_req_t req,
    output nsdt_pkg::nsdt_rec_t        rd_data
);
    import nsdt_pkg::*;

    nsdt_rec_t mem [MAX_RECORDS];
    nsdt_rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/nsdt_ctrl.sv
// ----------------------------------------------------------------------------
// nsdt_ctrl
// Scope state and event sequencing: reads the record on accept, decides the
// status, writes back on push and builds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module nsdt_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire nsdt_pkg::nsdt_in_t      s_data,
    input  wire logic                    out_free,
    output logic                         res_load,
    output nsdt_pkg::nsdt_out_t          res_data,
    output nsdt_pkg::nsdt_mem_req_t      mem_req,
    input  wire nsdt_pkg::nsdt_rec_t     rd_data
);
    import nsdt_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               state_reg, state_next;
    nsdt_in_t           item_reg;
    logic [ID_W-1:0]    cur_scope_reg, cur_scope_next;
    logic [DEPTH_W-1:0] cur_level_reg, cur_level_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic accept;
    logic push_ok;

    assign s_ready = (state_reg == S_IDLE) && out_free;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cur_scope_next = cur_scope_reg;
        cur_level_next = cur_level_reg;
        count_next     = count_reg;
        res_load       = 1'b0;
        push_ok        = 1'b0;
        res_data       = '0;
        res_data.record_id = item_reg.scope_id;

        mem_req         = '0;
        mem_req.rd_en   = accept;
        mem_req.rd_addr = ADDR_W'(s_data.scope_id);
        mem_req.wr_addr = ADDR_W'(item_reg.scope_id);
        mem_req.wr_data.parent  = cur_scope_reg;
        mem_req.wr_data.begin_t = item_reg.time_point;
        mem_req.wr_data.depth   = cur_level_reg;
        mem_req.wr_data.name    = item_reg.name_tag;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                res_load   = 1'b1;
                if (item_reg.func == FUNC_PUSH) begin
                    if (32'(count_reg) >= 32'(MAX_RECORDS)) begin
                        res_data.status = ST_FULL;
                    end else if (32'(item_reg.scope_id) != 32'(count_reg)) begin
                        res_data.status = ST_PUSH_MISMATCH;
                    end else begin
                        push_ok             = 1'b1;
                        mem_req.wr_en       = 1'b1;
                        res_data.status     = ST_OK;
                        res_data.parent_id  = cur_scope_reg;
                        res_data.nest_depth = cur_level_reg;
                        res_data.begin_time = item_reg.time_point;
                        res_data.duration   = '1;
                        res_data.scope_name = item_reg.name_tag;
                        cur_scope_next      = item_reg.scope_id;
                        cur_level_next      = cur_level_reg + 1'b1;
                        count_next          = count_reg + 1'b1;
                    end
                end else begin
                    if (item_reg.scope_id != cur_scope_reg) begin
                        res_data.status = ST_POP_NOT_CURRENT;
                    end else if (item_reg.scope_id == '0) begin
                        res_data.status = ST_POP_ROOT;
                    end else begin
                        // record of the current scope, read at accept
                        res_data.status     = ST_OK;
                        res_data.parent_id  = rd_data.parent;
                        res_data.nest_depth = rd_data.depth;
                        res_data.begin_time = rd_data.begin_t;
                        res_data.duration   = item_reg.time_point - rd_data.begin_t;
                        res_data.scope_name = rd_data.name;
                        cur_scope_next      = rd_data.parent;
                        cur_level_next      = cur_level_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_scope_reg <= '0;
            cur_level_reg <= DEPTH_W'(1);
            count_reg     <= CNT_W'(1);
        end else begin
            state_reg     <= state_next;
            cur_scope_reg <= cur_scope_next;
            cur_level_reg <= cur_level_next;
            count_reg     <= count_next;
        end
    end

    // write-back only in the execute cycle, never overlapping a read
    a_wr_in_exec : assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == S_EXEC) && !mem_req.rd_en)
        else $error("record write outside execute cycle");

    a_cnt_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (32'(count_reg) <= 32'(MAX_RECORDS)))
        else $error("record count out of range");

    a_push_cnt : assert property (@(posedge aclk) disable iff (!aresetn)
        push_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("record count not raised after push");

    a_exec_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC) && res_load && !s_ready)
        else $error("accepted beat not executed next cycle");

endmodule

`default_nettype wire

FILE: bench/nested_scope_duration_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_scope_duration_tracker_test
// Self-checking bench for the nested scope tracker. A scope ledger keeps its
// own record table and current scope, and predicts one result per accepted
// event. Every beat leaving the block is compared field by field with the
// oldest prediction. Stimulus is a short directed opener, then mostly
// well-formed push/pop traffic with noise mixed in, with random gaps on both
// sides. The run then unwinds to the root.
// ----------------------------------------------------------------------------
module nested_scope_duration_tracker_test;

    import nsdt_pkg::*;

    localparam int RANDOM_EVENTS = 1580;
    localparam int CALM_EVENTS   = 150;
    localparam int LONG_HOLD     = 600;
    localparam int STALL_LIMIT   = 4000;

    class scope_ledger;
        nsdt_out_t          awaited [$];
        logic [ID_W-1:0]    open_parent [MAX_RECORDS];
        logic [TIME_W-1:0]  open_start  [MAX_RECORDS];
        logic [DEPTH_W-1:0] open_level  [MAX_RECORDS];
        logic [NAME_W-1:0]  open_name   [MAX_RECORDS];
        logic [ID_W-1:0]    cur_scope;
        logic [DEPTH_W-1:0] cur_level;
        logic [CNT_W-1:0]   rec_count;
        int                 errors;
        int                 deepest;
        int                 seen [5];

        function new();
            cur_scope = '0;
            cur_level = DEPTH_W'(1);
            rec_count = CNT_W'(1);
            errors    = 0;
            deepest   = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void note_event(nsdt_in_t ev);
            nsdt_out_t res;
            res           = '0;
            res.record_id = ev.scope_id;
            if (ev.func == FUNC_PUSH) begin
                if (rec_count >= MAX_RECORDS) begin
                    res.status = ST_FULL;
                end else if (CNT_W'(ev.scope_id) != rec_count) begin
                    res.status = ST_PUSH_MISMATCH;
                end else begin
                    open_parent[ev.scope_id] = cur_scope;
                    open_start[ev.scope_id]  = ev.time_point;
                    open_level[ev.scope_id]  = cur_level;
                    open_name[ev.scope_id]   = ev.name_tag;
                    res.status     = ST_OK;
                    res.parent_id  = cur_scope;
                    res.nest_depth = cur_level;
                    res.begin_time = ev.time_point;
                    res.duration   = '1;
                    res.scope_name = ev.name_tag;
                    if (cur_level > deepest) deepest = cur_level;
                    cur_scope = ev.scope_id;
                    cur_level = cur_level + 1'b1;
                    rec_count = rec_count + 1'b1;
                end
            end else if (ev.scope_id != cur_scope) begin
                res.status = ST_POP_NOT_CURRENT;
            end else if (ev.scope_id == '0) begin
                res.status = ST_POP_ROOT;
            end else begin
                res.status     = ST_OK;
                res.parent_id  = open_parent[ev.scope_id];
                res.nest_depth = open_level[ev.scope_id];
                res.begin_time = open_start[ev.scope_id];
                res.duration   = ev.time_point - open_start[ev.scope_id];
                res.scope_name = open_name[ev.scope_id];
                cur_scope = open_parent[ev.scope_id];
                cur_level = cur_level - 1'b1;
            end
            seen[res.status]++;
            awaited.push_back(res);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_result(nsdt_out_t got);
            nsdt_out_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing awaited, got %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("record_id", want.record_id, got.record_id);
            compare_field("parent_id", want.parent_id, got.parent_id);
            compare_field("nest_depth", want.nest_depth, got.nest_depth);
            compare_field("begin_time", want.begin_time, got.begin_time);
            compare_field("duration", want.duration, got.duration);
            compare_field("scope_name", want.scope_name, got.scope_name);
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    nsdt_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    nsdt_out_t m_data;

    scope_ledger       sb = new();
    logic [TIME_W-1:0] clock_ns;
    bit                calm_tail;
    bit                hold_req;
    int                rx_hold_left;
    int                rx_stretch_left;
    bit                rx_gappy;
    int                tx_stretch_left;
    bit                tx_gappy;
    int                idle_cycles = 0;

    nested_scope_duration_tracker uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic nsdt_in_t event_beat(logic f, logic [ID_W-1:0] id,
                                            logic [TIME_W-1:0] t, logic [NAME_W-1:0] tag);
        nsdt_in_t ev;
        ev.func       = f;
        ev.scope_id   = id;
        ev.time_point = t;
        ev.name_tag   = tag;
        return ev;
    endfunction

    // mostly a rising clock, now and then a wild stamp or a jump close to wrap
    function automatic logic [TIME_W-1:0] next_time();
        int pick;
        pick = $urandom_range(0, 199);
        if (pick == 0) clock_ns = '1 - $urandom_range(0, 40000);
        if (pick < 12) return {$urandom, $urandom};
        clock_ns += $urandom_range(1, 5000);
        return clock_ns;
    endfunction

    function automatic nsdt_in_t random_event(bit tidy, int push_pct);
        nsdt_in_t ev;
        bit       can_push;
        bit       can_pop;
        ev.func       = FUNC_POP;
        ev.scope_id   = sb.cur_scope;
        ev.time_point = next_time();
        ev.name_tag   = NAME_W'($urandom);
        can_push      = sb.rec_count < MAX_RECORDS;
        can_pop       = sb.cur_scope != '0;
        if (tidy) begin
            if (can_push && (!can_pop || $urandom_range(0, 99) < push_pct)) begin
                ev.func     = FUNC_PUSH;
                ev.scope_id = sb.rec_count[ID_W-1:0];
            end
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    ev.func       = 1'($urandom_range(0, 1));
                    ev.scope_id   = ID_W'($urandom);
                    ev.time_point = {$urandom, $urandom};
                end
                1: begin
                    ev.func     = FUNC_PUSH;
                    ev.scope_id = $urandom_range(0, 1) ? ID_W'(sb.rec_count + 1'b1)
                                                       : ID_W'(sb.rec_count - 1'b1);
                end
                2: ev.scope_id = sb.cur_scope ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                3: ev.scope_id = '0;
                default: begin
                    ev.func     = FUNC_PUSH;
                    ev.scope_id = '0;
                end
            endcase
        end
        return ev;
    endfunction

    task automatic send_beat(nsdt_in_t beat);
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(beat);
    endtask

    task automatic input_gap();
        if (calm_tail) return;
        if (tx_stretch_left == 0) begin
            tx_stretch_left = $urandom_range(20, 120);
            tx_gappy        = $urandom_range(0, 2) != 0;
        end
        tx_stretch_left--;
        if (tx_gappy && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // result side: random stall bursts, one long hold on request
    initial begin
        m_ready         = 1'b0;
        rx_hold_left    = 0;
        rx_stretch_left = 0;
        rx_gappy        = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_stretch_left == 0) begin
                rx_stretch_left = $urandom_range(30, 150);
                rx_gappy        = $urandom_range(0, 2) != 0;
            end
            rx_stretch_left--;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                rx_hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!calm_tail && rx_gappy && $urandom_range(0, 5) == 0) begin
                rx_hold_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int depth;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        clock_ns        = '0;
        calm_tail       = 1'b0;
        hold_req        = 1'b0;
        tx_stretch_left = 0;
        tx_gappy        = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // opener: root pops, bad numbers, field extremes, wrapping durations
        send_beat(event_beat(FUNC_POP, 12'd0, 64'd0, 16'h0000));
        send_beat(event_beat(FUNC_POP, 12'hfff, '1, 16'hffff));
        send_beat(event_beat(FUNC_PUSH, 12'd0, 64'd7, 16'h1234));
        send_beat(event_beat(FUNC_PUSH, 12'hfff, '1, 16'hffff));
        send_beat(event_beat(FUNC_PUSH, 12'd1, 64'd0, 16'h0000));
        send_beat(event_beat(FUNC_PUSH, 12'd2, '1, 16'hffff));
        send_beat(event_beat(FUNC_PUSH, 12'd2, 64'd3, 16'h0f0f));
        send_beat(event_beat(FUNC_POP, 12'd1, 64'd9, 16'h0000));
        send_beat(event_beat(FUNC_POP, 12'd2, 64'd0, 16'h0000));
        input_gap();
        send_beat(event_beat(FUNC_POP, 12'd0, 64'd1, 16'h0000));
        send_beat(event_beat(FUNC_PUSH, 12'd3, 64'h8000_0000_0000_0000, 16'ha5a5));
        send_beat(event_beat(FUNC_POP, 12'd3, 64'h8000_0000_0000_0000, 16'h0000));
        send_beat(event_beat(FUNC_POP, 12'd1, '1, 16'hffff));
        send_beat(event_beat(FUNC_POP, 12'd0, '1, 16'h0000));
        send_beat(event_beat(FUNC_PUSH, 12'd4, 64'h5555_5555_5555_5555, 16'h5a5a));
        send_beat(event_beat(FUNC_PUSH, 12'd5, 64'haaaa_aaaa_aaaa_aaaa, 16'h0001));
        send_beat(event_beat(FUNC_POP, 12'd5, 64'h5555_5555_5555_5555, 16'h8000));
        send_beat(event_beat(FUNC_POP, 12'd4, 64'h5555_5555_5555_5555, 16'h0000));
        input_gap();

        clock_ns = {$urandom, $urandom} >> $urandom_range(1, 40);
        for (int i = 0; i < RANDOM_EVENTS; i++) begin
            depth = sb.cur_level - 1;
            if (i == RANDOM_EVENTS - CALM_EVENTS) calm_tail = 1'b1;
            if ($urandom_range(0, 99) < 85)
                send_beat(random_event(1'b1, depth < 2 ? 70 : (depth > 48 ? 30 : 52)));
            else
                send_beat(random_event(1'b0, 0));
            if (i == 400) hold_req = 1'b1;
            if (i == 1000) begin
                // let the block run dry before carrying on
                s_valid <= 1'b0;
                while (sb.awaited.size() != 0) @(posedge aclk);
            end else begin
                input_gap();
            end
        end

        // tail: unwind to the root
        calm_tail = 1'b1;
        while (sb.cur_scope != '0)
            send_beat(random_event($urandom_range(0, 9) != 0, 50));
        send_beat(random_event(1'b1, 50));
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("%0d events: %0d scopes opened, %0d closed ok, deepest level %0d",
                 sb.seen[ST_OK] + sb.seen[ST_PUSH_MISMATCH] + sb.seen[ST_POP_NOT_CURRENT]
                 + sb.seen[ST_FULL] + sb.seen[ST_POP_ROOT],
                 sb.rec_count - 1, sb.seen[ST_OK] - (sb.rec_count - 1), sb.deepest);
        $display("rejected: %0d bad push number, %0d pop off current, %0d full, %0d root pop",
                 sb.seen[ST_PUSH_MISMATCH], sb.seen[ST_POP_NOT_CURRENT],
                 sb.seen[ST_FULL], sb.seen[ST_POP_ROOT]);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/nsdt_pkg.sv
src/nsdt_rec_mem.sv
src/nsdt_ctrl.sv
src/nested_scope_duration_tracker.sv
bench/nested_scope_duration_tracker_test.sv
